// ===== hw/rtl/lfps_pkg.sv =====
// ----------------------------------------------------------------------------
// lfps_pkg
// Shared constants, types and register codes of the line follower steering
// core.
// ----------------------------------------------------------------------------
package lfps_pkg;

  localparam int NUM_SENSORS = 16;
  localparam int SAMPLE_BITS = 12;
  localparam int THRESH_W    = 12;
  localparam int SUM_W       = 7;
  localparam int CNT_W       = 5;
  localparam int SUM_MAX     = 127;
  localparam int COUNT_MAX   = 31;
  localparam int POS_W       = 13;
  localparam int MIDDLE_Q8   = 1920;
  localparam int POS_MAX     = (NUM_SENSORS - 1) * 256;
  localparam int POS_NONE    = -256;
  localparam int DVD_W       = 21;
  localparam int DVS_W       = 32;
  localparam int INTEG_W     = 48;
  localparam int ACC_W       = 88;
  localparam int MUL_W       = 33;
  localparam int CORR_W      = 22;
  localparam int CORR_LIMIT  = 1048576;
  localparam int PWM_W       = 16;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_KP     = 3'd0,
    REG_KI     = 3'd1,
    REG_KD     = 3'd2,
    REG_CRUISE = 3'd3,
    REG_THRESH = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0]   kp;
    logic signed [31:0]   ki;
    logic signed [31:0]   kd;
    logic [PWM_W-1:0]     cruise;
    logic [THRESH_W-1:0]  thresh;
  } cfg_t;

  // One closed scan handed from the front to the back
  typedef struct packed {
    logic [SUM_W-1:0] index_sum;
    logic [CNT_W-1:0] hit_count;
    logic [31:0]      time_ms;
  } scan_t;

  typedef struct packed {
    logic signed [POS_W-1:0] position_q8;
    logic [PWM_W-1:0]        right_pwm;
    logic                    right_reverse;
    logic [PWM_W-1:0]        left_pwm;
    logic                    left_reverse;
  } result_t;

endpackage

// ===== hw/rtl/lfps_front.sv =====
// ----------------------------------------------------------------------------
// lfps_front
// Accumulates detected sensor indexes over a scan and emits one scan record
// when the last sample of the scan arrives.
// ----------------------------------------------------------------------------
module lfps_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [lfps_pkg::SAMPLE_BITS-1:0]    sample,
  input  logic [3:0]                          sensor_index,
  input  logic                                scan_last,
  input  logic [31:0]                         time_ms,
  input  logic [lfps_pkg::THRESH_W-1:0]       thresh,
  output logic                                push,
  output lfps_pkg::scan_t                     push_data,
  input  logic                                push_ready
);

  logic [lfps_pkg::SUM_W-1:0] sum_r, sum_nxt;
  logic [lfps_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [lfps_pkg::SUM_W:0]   sum_add;
  logic [lfps_pkg::CNT_W:0]   cnt_add;
  logic                       hit;
  logic                       accept;

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;

  // Detection and saturating accumulation, current sample included
  always_comb begin
    hit = (int'(sensor_index) < lfps_pkg::NUM_SENSORS) &&
          (17'(sample) > 17'(thresh));
    sum_add = (lfps_pkg::SUM_W+1)'(sum_r) + (lfps_pkg::SUM_W+1)'(sensor_index);
    cnt_add = (lfps_pkg::CNT_W+1)'(cnt_r) + (lfps_pkg::CNT_W+1)'(1);
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    if (hit) begin
      sum_nxt = (int'(sum_add) > lfps_pkg::SUM_MAX) ?
                lfps_pkg::SUM_W'(lfps_pkg::SUM_MAX) : sum_add[lfps_pkg::SUM_W-1:0];
      cnt_nxt = (int'(cnt_add) > lfps_pkg::COUNT_MAX) ?
                lfps_pkg::CNT_W'(lfps_pkg::COUNT_MAX) : cnt_add[lfps_pkg::CNT_W-1:0];
    end
  end

  assign push                = accept && scan_last;
  assign push_data.index_sum = sum_nxt;
  assign push_data.hit_count = cnt_nxt;
  assign push_data.time_ms   = time_ms;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
    end else if (accept) begin
      if (scan_last) begin
        sum_r <= '0;
        cnt_r <= '0;
      end else begin
        sum_r <= sum_nxt;
        cnt_r <= cnt_nxt;
      end
    end
  end

endmodule

// ===== hw/rtl/lfps_queue.sv =====
// ----------------------------------------------------------------------------
// lfps_queue
// Two-entry queue of closed scans between the front and the back.
// ----------------------------------------------------------------------------
module lfps_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  lfps_pkg::scan_t push_data,
  output logic            push_ready,
  input  logic            pop,
  output logic            pop_valid,
  output lfps_pkg::scan_t pop_data
);

  lfps_pkg::scan_t ent_r [2];
  logic            wr_ptr_r;
  logic            rd_ptr_r;
  logic [1:0]      cnt_r;
  logic            do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = ent_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      if (do_push && !do_pop)      cnt_r <= cnt_r + 2'd1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 2'd1;
    end
  end

endmodule

// ===== hw/rtl/lfps_div.sv =====
// ----------------------------------------------------------------------------
// lfps_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lfps_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [lfps_pkg::DVD_W-1:0]    dividend,
  input  logic [lfps_pkg::DVS_W-1:0]    divisor,
  output logic                          done,
  output logic [lfps_pkg::DVD_W-1:0]    quotient
);

  logic [lfps_pkg::DVD_W-1:0] quo_r;
  logic [lfps_pkg::DVS_W-1:0] dvs_r;
  logic [lfps_pkg::DVS_W:0]   rem_r;
  logic [lfps_pkg::DVS_W:0]   rem_sh;
  logic [lfps_pkg::DVS_W:0]   rem_sub;
  logic [4:0]                 step_r;
  logic                       busy_r;
  logic                       done_r;

  assign done     = done_r;
  assign quotient = quo_r;

  // One shift-subtract step
  always_comb begin
    rem_sh  = {rem_r[lfps_pkg::DVS_W-1:0], quo_r[lfps_pkg::DVD_W-1]};
    rem_sub = rem_sh - {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= 5'(lfps_pkg::DVD_W - 1);
        quo_r  <= dividend;
        dvs_r  <= divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        if (rem_sh >= {1'b0, dvs_r}) begin
          rem_r <= rem_sub;
          quo_r <= {quo_r[lfps_pkg::DVD_W-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          quo_r <= {quo_r[lfps_pkg::DVD_W-2:0], 1'b0};
        end
        if (step_r == 5'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r - 5'd1;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/lfps_back.sv =====
// ----------------------------------------------------------------------------
// lfps_back
// Per-scan sequencer: centroid, integral and derivative, PID sum over a
// shared multiplier, and wheel command output register.
// ----------------------------------------------------------------------------
module lfps_back (
  input  logic              clk,
  input  logic              rst_n,
  input  lfps_pkg::cfg_t    cfg,
  input  logic              scan_valid,
  input  lfps_pkg::scan_t   scan_data,
  output logic              scan_pop,
  output logic              res_valid,
  input  logic              res_ready,
  output lfps_pkg::result_t res_data
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_POS_WAIT, ST_ERR, ST_INT_MUL, ST_INT_ADD, ST_DER_WAIT,
    ST_PID, ST_CORR, ST_FINISH
  } state_t;

  localparam int PW = lfps_pkg::POS_W;

  state_t                                state_r;
  logic [2:0]                            phase_r;
  lfps_pkg::scan_t                       scan_r;
  logic signed [PW-1:0]                  pos_r;
  logic signed [PW-1:0]                  err_r;
  logic [31:0]                           dt_r;
  logic signed [lfps_pkg::INTEG_W-1:0]   integ_r;
  logic signed [PW-1:0]                  prev_err_r;
  logic [31:0]                           prev_time_r;
  logic                                  neg_r;
  logic signed [lfps_pkg::CORR_W-1:0]    deriv_r;
  logic signed [2*lfps_pkg::MUL_W-1:0]   prod_r;
  logic signed [lfps_pkg::ACC_W-1:0]     acc_r;
  logic signed [lfps_pkg::CORR_W-1:0]    corr_r;
  logic                                  out_valid_r;
  lfps_pkg::result_t                     out_r;

  logic signed [lfps_pkg::MUL_W-1:0]     mul_a, mul_b;
  logic                                  div_start, div_done;
  logic [lfps_pkg::DVD_W-1:0]            div_dvd, div_q;
  logic [lfps_pkg::DVS_W-1:0]            div_dvs;
  logic signed [lfps_pkg::INTEG_W:0]     integ_sum;
  logic signed [PW:0]                    diff;
  logic [PW:0]                           diff_mag;
  logic signed [lfps_pkg::ACC_W-1:0]     prod_ext;
  logic signed [lfps_pkg::ACC_W-1:0]     acc_rnd;
  logic signed [lfps_pkg::ACC_W-33:0]    corr_full;
  logic signed [lfps_pkg::CORR_W:0]      left_v, right_v;
  logic [lfps_pkg::CORR_W:0]             left_m, right_m;
  logic                                  slot_free;

  lfps_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  assign res_valid = out_valid_r;
  assign res_data  = out_r;
  assign slot_free = !out_valid_r || res_ready;
  assign scan_pop  = (state_r == ST_IDLE) && scan_valid;

  // Divider operands: centroid on pop, derivative in the integral add step
  always_comb begin
    diff     = (PW+1)'(err_r) - (PW+1)'(prev_err_r);
    diff_mag = diff[PW] ? (PW+1)'(-diff) : (PW+1)'(diff);
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    if (state_r == ST_IDLE && scan_valid && scan_data.hit_count != '0) begin
      div_start = 1'b1;
      div_dvd   = lfps_pkg::DVD_W'({scan_data.index_sum, 8'd0});
      div_dvs   = lfps_pkg::DVS_W'(scan_data.hit_count);
    end else if (state_r == ST_INT_ADD && dt_r != '0) begin
      div_start = 1'b1;
      div_dvd   = lfps_pkg::DVD_W'({diff_mag, 8'd0});
      div_dvs   = dt_r;
    end
  end

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == ST_INT_MUL) begin
      mul_a = lfps_pkg::MUL_W'(err_r);
      mul_b = $signed({1'b0, dt_r});
    end else if (state_r == ST_PID) begin
      case (phase_r)
        3'd0: begin
          mul_a = lfps_pkg::MUL_W'(cfg.kp);
          mul_b = lfps_pkg::MUL_W'(err_r);
        end
        3'd1: begin
          mul_a = lfps_pkg::MUL_W'(cfg.kd);
          mul_b = lfps_pkg::MUL_W'(deriv_r);
        end
        3'd2: begin
          mul_a = lfps_pkg::MUL_W'(cfg.ki);
          mul_b = $signed({9'd0, integ_r[23:0]});
        end
        3'd3: begin
          mul_a = lfps_pkg::MUL_W'(cfg.ki);
          mul_b = lfps_pkg::MUL_W'($signed(integ_r[47:24]));
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end
  end

  // Integral, rounding toward zero and wheel arithmetic
  always_comb begin
    integ_sum = (lfps_pkg::INTEG_W+1)'(integ_r) +
                (lfps_pkg::INTEG_W+1)'(prod_r);
    prod_ext  = lfps_pkg::ACC_W'(prod_r);
    acc_rnd   = acc_r + (acc_r[lfps_pkg::ACC_W-1] ?
                lfps_pkg::ACC_W'(33'h0FFFFFFFF) : lfps_pkg::ACC_W'(0));
    corr_full = acc_rnd[lfps_pkg::ACC_W-1:32];
    if (corr_r > 0) begin
      left_v  = (lfps_pkg::CORR_W+1)'({1'b0, cfg.cruise});
      right_v = (lfps_pkg::CORR_W+1)'({1'b0, cfg.cruise}) -
                (lfps_pkg::CORR_W+1)'(corr_r);
    end else begin
      left_v  = (lfps_pkg::CORR_W+1)'({1'b0, cfg.cruise}) +
                (lfps_pkg::CORR_W+1)'(corr_r);
      right_v = (lfps_pkg::CORR_W+1)'({1'b0, cfg.cruise});
    end
    left_m  = left_v[lfps_pkg::CORR_W]  ? (lfps_pkg::CORR_W+1)'(-left_v)
                                        : (lfps_pkg::CORR_W+1)'(left_v);
    right_m = right_v[lfps_pkg::CORR_W] ? (lfps_pkg::CORR_W+1)'(-right_v)
                                        : (lfps_pkg::CORR_W+1)'(right_v);
  end

  // Free-running product register
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= '0;
      integ_r     <= '0;
      prev_err_r  <= '0;
      prev_time_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (res_ready && state_r != ST_FINISH) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (scan_valid) begin
            scan_r <= scan_data;
            if (scan_data.hit_count == '0) begin
              pos_r   <= PW'(lfps_pkg::POS_NONE);
              state_r <= ST_ERR;
            end else begin
              state_r <= ST_POS_WAIT;
            end
          end
        end
        ST_POS_WAIT: begin
          if (div_done) begin
            pos_r   <= (int'(div_q) > lfps_pkg::POS_MAX) ?
                       PW'(lfps_pkg::POS_MAX) : PW'(div_q);
            state_r <= ST_ERR;
          end
        end
        ST_ERR: begin
          err_r   <= pos_r - PW'(lfps_pkg::MIDDLE_Q8);
          dt_r    <= scan_r.time_ms - prev_time_r;
          state_r <= ST_INT_MUL;
        end
        ST_INT_MUL: begin
          state_r <= ST_INT_ADD;
        end
        ST_INT_ADD: begin
          // Saturate to the signed 48-bit range
          if (integ_sum[lfps_pkg::INTEG_W] != integ_sum[lfps_pkg::INTEG_W-1]) begin
            integ_r <= integ_sum[lfps_pkg::INTEG_W] ?
                       {1'b1, {(lfps_pkg::INTEG_W-1){1'b0}}} :
                       {1'b0, {(lfps_pkg::INTEG_W-1){1'b1}}};
          end else begin
            integ_r <= integ_sum[lfps_pkg::INTEG_W-1:0];
          end
          neg_r       <= diff[PW];
          prev_err_r  <= err_r;
          prev_time_r <= scan_r.time_ms;
          phase_r     <= '0;
          if (dt_r == '0) begin
            deriv_r <= '0;
            state_r <= ST_PID;
          end else begin
            state_r <= ST_DER_WAIT;
          end
        end
        ST_DER_WAIT: begin
          if (div_done) begin
            deriv_r <= neg_r ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
            state_r <= ST_PID;
          end
        end
        ST_PID: begin
          // Product of phase n-1 lands in the accumulator during phase n
          case (phase_r)
            3'd1:    acc_r <= prod_ext <<< 8;
            3'd2:    acc_r <= acc_r + prod_ext;
            3'd3:    acc_r <= acc_r + (prod_ext <<< 8);
            3'd4:    acc_r <= acc_r + (prod_ext <<< 32);
            default: acc_r <= acc_r;
          endcase
          if (phase_r == 3'd4) state_r <= ST_CORR;
          else                 phase_r <= phase_r + 3'd1;
        end
        ST_CORR: begin
          if (corr_full > lfps_pkg::CORR_LIMIT)
            corr_r <= lfps_pkg::CORR_W'(lfps_pkg::CORR_LIMIT);
          else if (corr_full < -lfps_pkg::CORR_LIMIT)
            corr_r <= lfps_pkg::CORR_W'(-lfps_pkg::CORR_LIMIT);
          else
            corr_r <= corr_full[lfps_pkg::CORR_W-1:0];
          state_r <= ST_FINISH;
        end
        ST_FINISH: begin
          if (slot_free) begin
            out_valid_r         <= 1'b1;
            out_r.left_reverse  <= left_v[lfps_pkg::CORR_W];
            out_r.left_pwm      <= (left_m > 23'd65535) ? 16'hFFFF : left_m[15:0];
            out_r.right_reverse <= right_v[lfps_pkg::CORR_W];
            out_r.right_pwm     <= (right_m > 23'd65535) ? 16'hFFFF : right_m[15:0];
            out_r.position_q8   <= pos_r;
            state_r             <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/line_follow_pid_steering_core.sv =====
// ----------------------------------------------------------------------------
// line_follow_pid_steering_core
// Line sensor centroid detector with a fixed-point PID steering loop.
// ----------------------------------------------------------------------------
// Samples are taken one per clock while the queue has room; the front accumulates
// each scan and queues it (two scans deep) for the back, which closes one scan at
// a time with the centroid division (skipped when no sensor sees the line), the
// derivative division (skipped when dt is 0) and the integral, the four PID
// products on one shared 33x33 multiplier, the clamp and the output handoff, plus
// any wait on out_tready. Sustained scan rate is set by that back sequencer;
// input stalls only when two closed scans are already waiting. Each closed scan
// yields one wheel command request; other samples yield none.
module line_follow_pid_steering_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // sample[11:0], sensor_index[15:12], time_ms[47:16]
  input  logic        in_tlast,   // scan_last
  output logic        out_tvalid,
  input  logic        out_tready,
  // left_reverse[0], left_pwm[16:1], right_reverse[17], right_pwm[33:18],
  // position_q8[46:34], zero[47]
  output logic [47:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  lfps_pkg::cfg_t    cfg_r;
  lfps_pkg::scan_t   push_data, pop_data;
  lfps_pkg::result_t res;
  logic              push, push_ready, pop, pop_valid;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp     <= 32'sd131072000;
      cfg_r.ki     <= '0;
      cfg_r.kd     <= '0;
      cfg_r.cruise <= 16'd40000;
      cfg_r.thresh <= 12'd1000;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lfps_pkg::REG_KP:     cfg_r.kp     <= cfg_data;
        lfps_pkg::REG_KI:     cfg_r.ki     <= cfg_data;
        lfps_pkg::REG_KD:     cfg_r.kd     <= cfg_data;
        lfps_pkg::REG_CRUISE: cfg_r.cruise <= cfg_data[15:0];
        lfps_pkg::REG_THRESH: cfg_r.thresh <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  lfps_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .sample       (in_tdata[11:0]),
    .sensor_index (in_tdata[15:12]),
    .scan_last    (in_tlast),
    .time_ms      (in_tdata[47:16]),
    .thresh       (cfg_r.thresh),
    .push         (push),
    .push_data    (push_data),
    .push_ready   (push_ready)
  );

  lfps_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data)
  );

  lfps_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .scan_valid (pop_valid),
    .scan_data  (pop_data),
    .scan_pop   (pop),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res_data   (res)
  );

  assign out_tdata = {1'b0, res};

  // Position is either the no-line code or within the sensor span
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(res.position_q8) == 13'sd0 - 13'sd256) ||
                   (!res.position_q8[12] && res.position_q8 <= 13'd3840))
    else $error("position out of range");

  // A reversed wheel always has a nonzero magnitude
  a_rev_mag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!res.left_reverse || res.left_pwm != '0) &&
                   (!res.right_reverse || res.right_pwm != '0))
    else $error("reverse with zero magnitude");

  // The outer wheel runs forward at cruise speed
  a_outer_cruise: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!res.left_reverse && res.left_pwm == cfg_r.cruise) ||
                   (!res.right_reverse && res.right_pwm == cfg_r.cruise))
    else $error("no wheel at cruise speed");

endmodule

// ===== tb/line_follow_pid_steering_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_follow_pid_steering_core_tb
// Self-checking bench for the line sensor centroid and PID steering core.
// Sensor scans are streamed in with random gaps, and a local copy of the
// centroid and PID arithmetic predicts each wheel command. Every command from
// the block is compared field by field. Gain, speed and threshold settings are
// changed between phases while the core is idle.
// ----------------------------------------------------------------------------
module line_follow_pid_steering_core_tb;

  localparam int SETTLE_CYCLES = 200;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam longint INTEG_HI = 64'sd140737488355327;
  localparam longint INTEG_LO = -64'sd140737488355328;

  typedef struct {
    logic [11:0] sample;
    logic [3:0]  sensor;
    logic        last;
    logic [31:0] stamp;
  } sample_req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;  // sample[11:0], sensor_index[15:12], time_ms[47:16]
  logic        in_tlast = 1'b0;  // scan_last
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // left_reverse[0], left_pwm[16:1], right_reverse[17], right_pwm[33:18],
  // position_q8[46:34], zero[47]
  logic [47:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  line_follow_pid_steering_core DUT (.*);

  always #10 clk = ~clk;

  // Predictor state and its copy of the registers
  logic signed [31:0] kp_q16, ki_q16, kd_q16;
  logic [15:0]        cruise;
  logic [11:0]        thresh;
  int unsigned        index_sum, hit_count;
  longint             integ_acc;
  longint             prev_err;
  logic [31:0]        prev_stamp;

  sample_req_t         pending_samples[$];
  lfps_pkg::result_t   wheel_cmds[$];
  int          fail_count = 0;
  int          scans_closed = 0;
  int          samples_sent = 0;
  longint      cycle_count = 0;
  logic        in_fire = 1'b0;
  int          in_gap = 0;
  int          out_gap = 0;
  logic [31:0] clock_ms = 0;

  // Signed speed to reverse bit and saturated magnitude
  function automatic logic [16:0] wheel_drive(longint speed);
    longint mag;
    mag = speed < 0 ? -speed : speed;
    if (mag > 65535) mag = 65535;
    return {speed < 0 ? 1'b1 : 1'b0, mag[15:0]};
  endfunction

  // Accumulate one sample; on the last of a scan, run the PID step
  function automatic void steer_predict(sample_req_t s);
    longint pos, err, deriv, corr, left, right, dt64;
    logic [31:0] dt;
    logic signed [127:0] total, kp_w, ki_w, kd_w;
    logic [16:0] lw, rw;
    lfps_pkg::result_t r;
    if (s.sample > thresh) begin
      index_sum = index_sum + s.sensor > lfps_pkg::SUM_MAX ?
                  lfps_pkg::SUM_MAX : index_sum + s.sensor;
      hit_count = hit_count + 1 > lfps_pkg::COUNT_MAX ?
                  lfps_pkg::COUNT_MAX : hit_count + 1;
    end
    if (!s.last) return;
    if (hit_count == 0) pos = lfps_pkg::POS_NONE;
    else begin
      pos = (index_sum * 256) / hit_count;
      if (pos > lfps_pkg::POS_MAX) pos = lfps_pkg::POS_MAX;
    end
    index_sum = 0;
    hit_count = 0;
    err = pos - lfps_pkg::MIDDLE_Q8;
    dt = s.stamp - prev_stamp;
    dt64 = longint'({32'd0, dt});
    integ_acc = integ_acc + err * dt64;
    if (integ_acc > INTEG_HI) integ_acc = INTEG_HI;
    if (integ_acc < INTEG_LO) integ_acc = INTEG_LO;
    deriv = dt == 0 ? 0 : ((err - prev_err) * 256) / dt64;
    // Sum in Q.32, then truncate toward zero
    kp_w = kp_q16;
    ki_w = ki_q16;
    kd_w = kd_q16;
    total = kp_w * err * 256 + kd_w * deriv + ki_w * integ_acc * 256;
    total = total / (128'sd1 <<< 32);
    if (total > lfps_pkg::CORR_LIMIT) total = lfps_pkg::CORR_LIMIT;
    if (total < -lfps_pkg::CORR_LIMIT) total = -lfps_pkg::CORR_LIMIT;
    corr = total[63:0];
    prev_stamp = s.stamp;
    prev_err = err;
    if (corr > 0) begin
      left = cruise;
      right = longint'(cruise) - corr;
    end else begin
      left = longint'(cruise) + corr;
      right = cruise;
    end
    lw = wheel_drive(left);
    rw = wheel_drive(right);
    r.left_reverse = lw[16];
    r.left_pwm = lw[15:0];
    r.right_reverse = rw[16];
    r.right_pwm = rw[15:0];
    r.position_q8 = pos[12:0];
    wheel_cmds.push_back(r);
  endfunction

  // Sample side: predict on accepted requests, track register writes
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    in_fire <= in_tvalid && in_tready;
    if (!rst_n) begin
      kp_q16 = 131072000;
      ki_q16 = 0;
      kd_q16 = 0;
      cruise = 40000;
      thresh = 1000;
      index_sum = 0;
      hit_count = 0;
      integ_acc = 0;
      prev_err = 0;
      prev_stamp = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        sample_req_t s;
        s.sample = in_tdata[11:0];
        s.sensor = in_tdata[15:12];
        s.stamp = in_tdata[47:16];
        s.last = in_tlast;
        steer_predict(s);
        samples_sent++;
      end
      if (cfg_valid && cfg_ready) begin
        case (lfps_pkg::reg_idx_t'(cfg_index))
          lfps_pkg::REG_KP:     kp_q16 = cfg_data;
          lfps_pkg::REG_KI:     ki_q16 = cfg_data;
          lfps_pkg::REG_KD:     kd_q16 = cfg_data;
          lfps_pkg::REG_CRUISE: cruise = cfg_data[15:0];
          lfps_pkg::REG_THRESH: thresh = cfg_data[11:0];
          default: ;
        endcase
      end
    end
  end

  // Wheel command checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      lfps_pkg::result_t got, want;
      got = out_tdata[46:0];
      if (wheel_cmds.size() == 0) begin
        $error("unexpected wheel command %h", out_tdata);
        fail_count++;
      end else begin
        want = wheel_cmds.pop_front();
        scans_closed++;
        if (got.left_reverse !== want.left_reverse) begin
          $error("left_reverse exp %0d got %0d", want.left_reverse, got.left_reverse);
          fail_count++;
        end
        if (got.left_pwm !== want.left_pwm) begin
          $error("left_pwm exp %0d got %0d", want.left_pwm, got.left_pwm);
          fail_count++;
        end
        if (got.right_reverse !== want.right_reverse) begin
          $error("right_reverse exp %0d got %0d", want.right_reverse, got.right_reverse);
          fail_count++;
        end
        if (got.right_pwm !== want.right_pwm) begin
          $error("right_pwm exp %0d got %0d", want.right_pwm, got.right_pwm);
          fail_count++;
        end
        if (got.position_q8 !== want.position_q8) begin
          $error("position_q8 exp %0d got %0d", want.position_q8, got.position_q8);
          fail_count++;
        end
      end
    end
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(8, 60);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // Sample driver, fed from the pending queue
  always @(negedge clk) begin
    if (rst_n && !(in_tvalid && !in_fire)) begin
      if (in_gap > 0 || pending_samples.size() == 0) begin
        in_tvalid <= 1'b0;
        if (in_gap > 0) in_gap <= in_gap - 1;
      end else begin
        sample_req_t s;
        s = pending_samples.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= {s.stamp, s.sensor, s.sample};
        in_tlast <= s.last;
        in_gap <= pick_gap();
      end
    end
  end

  // Result side stalls
  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_tready <= 1'b0;
      out_gap <= out_gap - 1;
    end else begin
      out_tready <= 1'b1;
      out_gap <= pick_gap();
    end
  end

  // Run timeout
  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic push_sample(logic [11:0] smp, logic [3:0] idx, logic last,
                             logic [31:0] stamp);
    sample_req_t s;
    s.sample = smp;
    s.sensor = idx;
    s.last = last;
    s.stamp = stamp;
    pending_samples.push_back(s);
  endtask

  task automatic write_reg(lfps_pkg::reg_idx_t idx, logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait for the core to drain before touching registers or ending
  task automatic wait_idle();
    while (pending_samples.size() != 0 || in_tvalid || wheel_cmds.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One random scan; mostly well formed, sometimes long to saturate counts
  task automatic push_scan();
    int len;
    logic [31:0] step;
    len = $urandom_range(0, 15) == 0 ? $urandom_range(32, 45) : $urandom_range(1, 16);
    for (int i = 0; i < len; i++) begin
      logic [11:0] smp;
      smp = $urandom_range(0, 1) ? (thresh + 12'($urandom_range(1, 300))) : 12'($urandom);
      push_sample(smp, 4'($urandom), i == len - 1, $urandom);
    end
    case ($urandom_range(0, 9))
      0: step = 0;
      1: step = $urandom;
      default: step = $urandom_range(1, 40);
    endcase
    clock_ms = clock_ms + step;
    pending_samples[$].stamp = clock_ms;
  endtask

  task automatic random_phase(int scans);
    for (int i = 0; i < scans; i++) push_scan();
    wait_idle();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: no line seen, full array at full scale, zero dt, wrap
    push_sample(12'd0, 4'd0, 1'b1, 32'd10);
    for (int i = 0; i < 16; i++) push_sample(12'hFFF, 4'(i), i == 15, 32'd10);
    push_sample(12'hFFF, 4'd15, 1'b1, 32'hFFFF_FFF0);
    push_sample(12'hFFF, 4'd15, 1'b1, 32'd5);
    clock_ms = 5;
    wait_idle();

    random_phase(20);

    // Extremes of every register
    write_reg(lfps_pkg::REG_KP, 32'h7FFF_FFFF);
    write_reg(lfps_pkg::REG_KI, 32'h8000_0000);
    write_reg(lfps_pkg::REG_KD, 32'h7FFF_FFFF);
    write_reg(lfps_pkg::REG_CRUISE, 32'd0);
    write_reg(lfps_pkg::REG_THRESH, 32'd0);
    random_phase(20);

    write_reg(lfps_pkg::REG_KP, 32'h8000_0000);
    write_reg(lfps_pkg::REG_KI, 32'h7FFF_FFFF);
    write_reg(lfps_pkg::REG_KD, 32'h8000_0000);
    write_reg(lfps_pkg::REG_CRUISE, 32'd65535);
    write_reg(lfps_pkg::REG_THRESH, 32'd4095);
    random_phase(15);

    // Random settings, KI kept moderate and KP moderate in some phases
    for (int p = 0; p < 4; p++) begin
      write_reg(lfps_pkg::REG_KP, $urandom_range(0, 1) ? $urandom :
                32'($signed($urandom_range(0, 200000)) - 100000));
      write_reg(lfps_pkg::REG_KI, 32'($signed($urandom_range(0, 2000)) - 1000));
      write_reg(lfps_pkg::REG_KD, $urandom);
      write_reg(lfps_pkg::REG_CRUISE, $urandom_range(0, 65535));
      write_reg(lfps_pkg::REG_THRESH, $urandom_range(0, 4095));
      random_phase(22);
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d samples in %0d closed scans over several gain, speed and",
             samples_sent, scans_closed);
    $display("threshold settings, with random stalls on both streams.");
    if (fail_count == 0 && wheel_cmds.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
